/* rtl/rmco_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmco_pkg
// Shared types and codes of the circle occlusion ray marcher: register
// layout, microcode word, sequencer/datapath control and status.
// ----------------------------------------------------------------------------
package rmco_pkg;

	localparam int POS_W   = 23;
	localparam int DIM_W   = 12;
	localparam int RAD_W   = 11;
	localparam int IDX_W   = 11;
	localparam int CNT_W   = 12;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int PC_W    = 4;

	localparam logic signed [POS_W-1:0] POS_MAX = 23'sh3FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 23'sh400000;
	localparam logic [CNT_W-1:0] DRAWN_MAX = 12'hFFF;

	// Outcome codes.
	localparam logic [1:0] OUT_LEFT  = 2'd0;
	localparam logic [1:0] OUT_HIT   = 2'd1;
	localparam logic [1:0] OUT_LIMIT = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SRC_X  = 3'd2;
	localparam logic [2:0] REG_SRC_Y  = 3'd3;
	localparam logic [2:0] REG_SRC_R  = 3'd4;
	localparam logic [2:0] REG_OBS_X  = 3'd5;
	localparam logic [2:0] REG_OBS_Y  = 3'd6;
	localparam logic [2:0] REG_OBS_R  = 3'd7;

	typedef logic [3:0] op_t;
	typedef logic [2:0] cond_t;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations.
	localparam op_t OP_IDLE      = 4'd0;
	localparam op_t OP_CORDIC    = 4'd1;
	localparam op_t OP_ROUND     = 4'd2;
	localparam op_t OP_MUL_START = 4'd3;
	localparam op_t OP_START     = 4'd4;
	localparam op_t OP_MOVE      = 4'd5;
	localparam op_t OP_SQUARE    = 4'd6;
	localparam op_t OP_TEST      = 4'd7;
	localparam op_t OP_DONE      = 4'd8;

	// Jump conditions: the jump is taken when the condition is true.
	localparam cond_t C_NEXT      = 3'd0;
	localparam cond_t C_JUMP      = 3'd1;
	localparam cond_t C_NO_START  = 3'd2;
	localparam cond_t C_ITER_MORE = 3'd3;
	localparam cond_t C_CONTINUE  = 3'd4;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} ctrl_t;

	typedef struct packed {
		logic iter_more;
		logic cont;
	} stat_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] src_x;
		logic [DIM_W-1:0] src_y;
		logic [RAD_W-1:0] src_r;
		logic [DIM_W-1:0] obs_x;
		logic [DIM_W-1:0] obs_y;
		logic [RAD_W-1:0] obs_r;
	} cfg_t;

endpackage

/* rtl/rmco_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmco_regs
// Configuration registers behind an APB-style port, one per word address.
// ----------------------------------------------------------------------------
module rmco_regs import rmco_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 12'd1200;
			cfg_q.height <= 12'd900;
			cfg_q.src_x  <= 12'd200;
			cfg_q.src_y  <= 12'd200;
			cfg_q.src_r  <= 11'd80;
			cfg_q.obs_x  <= 12'd650;
			cfg_q.obs_y  <= 12'd300;
			cfg_q.obs_r  <= 11'd140;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[DIM_W-1:0];
				REG_SRC_X:  cfg_q.src_x  <= pwdata[DIM_W-1:0];
				REG_SRC_Y:  cfg_q.src_y  <= pwdata[DIM_W-1:0];
				REG_SRC_R:  cfg_q.src_r  <= pwdata[RAD_W-1:0];
				REG_OBS_X:  cfg_q.obs_x  <= pwdata[DIM_W-1:0];
				REG_OBS_Y:  cfg_q.obs_y  <= pwdata[DIM_W-1:0];
				REG_OBS_R:  cfg_q.obs_r  <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = DATA_W'(cfg_q.width);
			REG_HEIGHT: prdata = DATA_W'(cfg_q.height);
			REG_SRC_X:  prdata = DATA_W'(cfg_q.src_x);
			REG_SRC_Y:  prdata = DATA_W'(cfg_q.src_y);
			REG_SRC_R:  prdata = DATA_W'(cfg_q.src_r);
			REG_OBS_X:  prdata = DATA_W'(cfg_q.obs_x);
			REG_OBS_Y:  prdata = DATA_W'(cfg_q.obs_y);
			REG_OBS_R:  prdata = DATA_W'(cfg_q.obs_r);
			default:    prdata = '0;
		endcase
	end

endmodule

/* rtl/rmco_ucode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmco_ucode
// Microcode sequencer: program counter, control store and jump logic.
// ----------------------------------------------------------------------------
module rmco_ucode import rmco_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy,
	output logic  done
);

	localparam pc_t PC_IDLE   = 4'd0;
	localparam pc_t PC_CORDIC = 4'd1;
	localparam pc_t PC_ROUND  = 4'd2;
	localparam pc_t PC_MULS   = 4'd3;
	localparam pc_t PC_START  = 4'd4;
	localparam pc_t PC_MOVE   = 4'd5;
	localparam pc_t PC_SQUARE = 4'd6;
	localparam pc_t PC_TEST   = 4'd7;
	localparam pc_t PC_DONE   = 4'd8;

	// The program. The march loop is square then test; the test step also
	// makes the next move when the ray goes on.
	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_IDLE:   w = '{op: OP_IDLE,      cond: C_NO_START,  target: PC_IDLE};
			PC_CORDIC: w = '{op: OP_CORDIC,    cond: C_ITER_MORE, target: PC_CORDIC};
			PC_ROUND:  w = '{op: OP_ROUND,     cond: C_NEXT,      target: PC_IDLE};
			PC_MULS:   w = '{op: OP_MUL_START, cond: C_NEXT,      target: PC_IDLE};
			PC_START:  w = '{op: OP_START,     cond: C_NEXT,      target: PC_IDLE};
			PC_MOVE:   w = '{op: OP_MOVE,      cond: C_NEXT,      target: PC_IDLE};
			PC_SQUARE: w = '{op: OP_SQUARE,    cond: C_NEXT,      target: PC_IDLE};
			PC_TEST:   w = '{op: OP_TEST,      cond: C_CONTINUE,  target: PC_SQUARE};
			PC_DONE:   w = '{op: OP_DONE,      cond: C_JUMP,      target: PC_IDLE};
			default:   w = '{op: OP_IDLE,      cond: C_JUMP,      target: PC_IDLE};
		endcase
		return w;
	endfunction

	pc_t    pc_q;
	pc_t    pc_next;
	uword_t word;
	logic   jump;
	logic   accept;

	assign word   = ucode_rom(pc_q);
	assign busy   = (pc_q != PC_IDLE);
	assign accept = start && !busy;
	assign done   = (word.op == OP_DONE);

	assign ctrl.op   = word.op;
	assign ctrl.load = accept;

	always_comb begin
		case (word.cond)
			C_NEXT:      jump = 1'b0;
			C_JUMP:      jump = 1'b1;
			C_NO_START:  jump = !start;
			C_ITER_MORE: jump = stat.iter_more;
			C_CONTINUE:  jump = stat.cont;
			default:     jump = 1'b1;
		endcase
		pc_next = jump ? word.target : pc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer did not leave idle after a transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer did not return to idle after a result");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe raised while the sequencer was idle");

endmodule

/* rtl/rmco_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmco_datapath
// Datapath of the ray marcher: CORDIC rotator for the ray direction, two
// shared multipliers for the start point and squared distance, and the
// march position registers with saturation and stop tests.
// ----------------------------------------------------------------------------
module rmco_datapath import rmco_pkg::*; #(
	parameter int RAYS_COUNT = 2048,
	parameter int MAX_STEPS  = 4095
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_t                   ctrl,
	input  cfg_t                    cfg,
	input  logic [IDX_W-1:0]        ray_index,
	output stat_t                   stat,
	output logic signed [POS_W-1:0] end_x,
	output logic signed [POS_W-1:0] end_y,
	output logic [1:0]              outcome,
	output logic [CNT_W-1:0]        drawn_count
);

	localparam int PH_SHIFT = 32 - $clog2(RAYS_COUNT);
	localparam int STEP_W   = $clog2(MAX_STEPS + 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS);
	localparam logic [3:0] ITER_LAST = 4'd15;
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	localparam logic [29:0] ATAN [16] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861
	};

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [25:0] v);
		logic signed [POS_W-1:0] r;
		if (v > 26'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < 26'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = POS_W'(v);
		end
		return r;
	endfunction

	// Round a Q30 value to Q1.14 and clamp to one.
	function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [17:0] q;
		logic signed [15:0] r;
		t = 34'(v) + 34'sd32768;
		q = 18'(t >>> 16);
		if (q > 18'sd16384) begin
			r = 16'sd16384;
		end else if (q < -18'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = 16'(q);
		end
		return r;
	endfunction

	// CORDIC state
	logic signed [32:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic               flip_q;
	logic [3:0]         iter_q;

	// Direction and start
	logic signed [15:0] c_q, s_q;
	logic signed [11:0] dx_q, dy_q;
	logic signed [47:0] pa_q, pb_q;
	logic [21:0]        r2_q;

	// March state
	logic signed [POS_W-1:0] x_q, y_q;
	logic signed [23:0]      ex_q, ey_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        drawn_q;
	logic [1:0]              outcome_q;

	logic [31:0]        phase;
	logic               flip_in;
	logic signed [33:0] z_in;
	logic signed [32:0] xs, ys;
	logic signed [33:0] at;
	logic signed [15:0] c_new, s_new;
	logic signed [23:0] ma, mb_a, mb_b, mc;
	logic signed [47:0] prod_a, prod_b;
	logic signed [25:0] st_x, st_y;
	logic signed [POS_W-1:0] nx, ny;
	logic signed [23:0] ox, oy;
	logic [47:0]        dist_sq;
	logic               hit, off, limit;
	logic signed [POS_W-1:0] wx, hy;

	assign phase   = 32'(64'(ray_index) << PH_SHIFT);
	assign flip_in = phase[31] ^ phase[30];
	// The half-turn flip folds the phase into the right half plane.
	assign z_in    = 34'($signed({phase[31] ^ flip_in, phase[30:0]}));

	assign xs = cx_q >>> iter_q;
	assign ys = cy_q >>> iter_q;
	assign at = $signed({4'b0000, ATAN[iter_q]});

	assign c_new = flip_q ? -to_q14(cx_q) : to_q14(cx_q);
	assign s_new = flip_q ? -to_q14(cy_q) : to_q14(cy_q);

	// Both multipliers serve the start point and the squared distance.
	always_comb begin
		if (ctrl.op == OP_SQUARE) begin
			ma   = ex_q;
			mb_a = ex_q;
			mc   = ey_q;
			mb_b = ey_q;
		end else begin
			ma   = $signed({13'd0, cfg.src_r});
			mb_a = 24'(c_q);
			mc   = $signed({13'd0, cfg.src_r});
			mb_b = 24'(s_q);
		end
	end

	assign prod_a = ma * mb_a;
	assign prod_b = mc * mb_b;

	assign st_x = $signed({4'b0000, cfg.src_x, 10'd0}) + 26'((pa_q + 48'sd8) >>> 4);
	assign st_y = $signed({4'b0000, cfg.src_y, 10'd0}) + 26'((pb_q + 48'sd8) >>> 4);

	assign nx = sat_pos(26'(x_q) + 26'(dx_q));
	assign ny = sat_pos(26'(y_q) + 26'(dy_q));
	assign ox = $signed({2'b00, cfg.obs_x, 10'd0});
	assign oy = $signed({2'b00, cfg.obs_y, 10'd0});

	assign dist_sq = $unsigned(pa_q) + $unsigned(pb_q);
	assign hit     = dist_sq < {6'd0, r2_q, 20'd0};
	assign wx      = $signed({1'b0, cfg.width, 10'd0});
	assign hy      = $signed({1'b0, cfg.height, 10'd0});
	assign off     = x_q[POS_W-1] || (x_q > wx) || y_q[POS_W-1] || (y_q > hy);
	assign limit   = (step_q == STEP_LAST);

	assign stat.iter_more = (iter_q != ITER_LAST);
	assign stat.cont      = !hit && !off && !limit;

	assign end_x       = x_q;
	assign end_y       = y_q;
	assign outcome     = outcome_q;
	assign drawn_count = drawn_q;

	// Working registers with no reset.
	always_ff @(posedge clk) begin
		r2_q <= 22'(cfg.obs_r * cfg.obs_r);
		if (ctrl.load) begin
			cx_q   <= CORDIC_X0;
			cy_q   <= '0;
			cz_q   <= z_in;
			flip_q <= flip_in;
		end
		case (ctrl.op)
			OP_CORDIC: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			OP_ROUND: begin
				c_q <= c_new;
				s_q <= s_new;
			end
			OP_MUL_START: begin
				pa_q <= prod_a;
				pb_q <= prod_b;
				dx_q <= 12'((c_q + 16'sd8) >>> 4);
				dy_q <= 12'((s_q + 16'sd8) >>> 4);
			end
			OP_SQUARE: begin
				pa_q <= prod_a;
				pb_q <= prod_b;
			end
			OP_MOVE, OP_TEST: begin
				ex_q <= 24'(nx) - ox;
				ey_q <= 24'(ny) - oy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q    <= '0;
			x_q       <= '0;
			y_q       <= '0;
			step_q    <= '0;
			drawn_q   <= '0;
			outcome_q <= OUT_LEFT;
		end else begin
			if (ctrl.load) begin
				iter_q    <= '0;
				step_q    <= '0;
				drawn_q   <= '0;
				outcome_q <= OUT_LIMIT;
			end
			case (ctrl.op)
				OP_CORDIC: iter_q <= iter_q + 4'd1;
				OP_START: begin
					x_q <= sat_pos(st_x);
					y_q <= sat_pos(st_y);
				end
				OP_MOVE: begin
					x_q    <= nx;
					y_q    <= ny;
					step_q <= STEP_W'(1);
				end
				OP_TEST: begin
					if (hit) begin
						outcome_q <= OUT_HIT;
					end else if (off) begin
						outcome_q <= OUT_LEFT;
					end else begin
						if (drawn_q != DRAWN_MAX) begin
							drawn_q <= drawn_q + 12'd1;
						end
						if (limit) begin
							outcome_q <= OUT_LIMIT;
						end else begin
							x_q    <= nx;
							y_q    <= ny;
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(step_q) <= 32'(MAX_STEPS))
		else $error("step counter ran past the step limit");

	a_drawn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(drawn_q) <= 32'(step_q))
		else $error("more points plotted than steps taken");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		outcome_q <= OUT_LIMIT)
		else $error("outcome register holds an unknown code");

endmodule

/* rtl/ray_march_circle_occlusion_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_march_circle_occlusion_top
// Marches one ray from the rim of a source circle until it enters the
// obstacle circle, leaves the screen or reaches the step limit.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  command   start / busy                   ray_index
//  result    done (one-cycle strobe)        end_x, end_y, outcome, drawn_count
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  For a ray of N march steps busy stays high after the command transfer
//  up to and including the cycle that carries the done strobe, and a new
//  command is only taken once busy has fallen. Each march step takes a square
//  state and a test state on the shared multipliers, so the busy time grows
//  with N; the CORDIC loop sets most of the fixed part.
//  Reset puts the sequencer in idle and loads register defaults; no
//  clearing pass. The result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module ray_march_circle_occlusion_top import rmco_pkg::*; #(
	parameter int RAYS_COUNT = 2048,
	parameter int MAX_STEPS  = 4095
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [IDX_W-1:0]        ray_index,
	output logic                    done,
	output logic signed [POS_W-1:0] end_x,
	output logic signed [POS_W-1:0] end_y,
	output logic [1:0]              outcome,
	output logic [CNT_W-1:0]        drawn_count,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;

	rmco_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rmco_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	rmco_datapath #(
		.RAYS_COUNT (RAYS_COUNT),
		.MAX_STEPS  (MAX_STEPS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg         (cfg),
		.ray_index   (ray_index),
		.stat        (stat),
		.end_x       (end_x),
		.end_y       (end_y),
		.outcome     (outcome),
		.drawn_count (drawn_count)
	);

endmodule
